// ===== src/lpu_pkg.sv =====
`timescale 1ns / 1ps

package lpu_pkg;

    localparam logic [1:0] OP_KICK    = 2'd0;
    localparam logic [1:0] OP_DRIFT   = 2'd1;
    localparam logic [1:0] OP_MEASURE = 2'd2;

    localparam logic [2:0] REG_PERIOD_LEN      = 3'd0;
    localparam logic [2:0] REG_CELL_WIDTH      = 3'd1;
    localparam logic [2:0] REG_STEP_FRACTION   = 3'd2;
    localparam logic [2:0] REG_FIXED_STEP      = 3'd3;
    localparam logic [2:0] REG_ADAPTIVE_ENABLE = 3'd4;

    localparam logic [30:0] RST_PERIOD_LEN    = 31'd4194304;
    localparam logic [30:0] RST_CELL_WIDTH    = 31'd65536;
    localparam logic [16:0] RST_STEP_FRACTION = 17'd32768;
    localparam logic [30:0] RST_FIXED_STEP    = 31'd655;

    // numerator of the adaptive step is step_fraction * cell_width
    localparam int NUM_W       = 48;
    localparam int DIV_STEPS   = NUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic [30:0]        step_size;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic [30:0]        next_step;
        logic               step_valid;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [30:0] period_len;
        logic [30:0] cell_width;
        logic [16:0] step_fraction;
        logic [30:0] fixed_step;
        logic        adaptive_enable;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
    } t_status;

endpackage

// ===== src/lpu_if.sv =====
`timescale 1ns / 1ps

interface lpu_in_if;
    logic              valid;
    logic              ready;
    lpu_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lpu_out_if;
    logic               valid;
    logic               ready;
    lpu_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lpu_cfg_if;
    logic             valid;
    logic             ready;
    lpu_pkg::t_cfg_wr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/lpu_cfg_regs.sv =====
`timescale 1ns / 1ps

module lpu_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_valid,
    input  lpu_pkg::t_cfg_wr  i_wr,
    output logic              o_wr_ready,
    output lpu_pkg::t_cfg     o_cfg
);

    lpu_pkg::t_cfg r_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_len      <= lpu_pkg::RST_PERIOD_LEN;
            r_cfg.cell_width      <= lpu_pkg::RST_CELL_WIDTH;
            r_cfg.step_fraction   <= lpu_pkg::RST_STEP_FRACTION;
            r_cfg.fixed_step      <= lpu_pkg::RST_FIXED_STEP;
            r_cfg.adaptive_enable <= 1'b0;
        end else if (i_wr_valid) begin
            unique case (i_wr.index)
                lpu_pkg::REG_PERIOD_LEN:      r_cfg.period_len      <= i_wr.value[30:0];
                lpu_pkg::REG_CELL_WIDTH:      r_cfg.cell_width      <= i_wr.value[30:0];
                lpu_pkg::REG_STEP_FRACTION:   r_cfg.step_fraction   <= i_wr.value[16:0];
                lpu_pkg::REG_FIXED_STEP:      r_cfg.fixed_step      <= i_wr.value[30:0];
                lpu_pkg::REG_ADAPTIVE_ENABLE: r_cfg.adaptive_enable <= i_wr.value[0];
                default: ;
            endcase
        end
    end

endmodule

// ===== src/lpu_ctrl.sv =====
`timescale 1ns / 1ps

module lpu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lpu_pkg::t_status  i_status,
    output lpu_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [lpu_pkg::DIV_CNT_W-1:0] CNT_LAST =
        lpu_pkg::DIV_CNT_W'(lpu_pkg::DIV_STEPS - 1);

    logic [1:0]                    r_state, n_state;
    logic [lpu_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_out_valid, n_out_valid;
    logic                          out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    n_state       = i_status.need_div ? S_DIV : S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/lpu_dpath.sv =====
`timescale 1ns / 1ps

module lpu_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpu_pkg::t_in_item  i_item,
    input  lpu_pkg::t_cfg      i_cfg,
    input  lpu_pkg::t_cmd      i_cmd,
    output lpu_pkg::t_status   o_status,
    output lpu_pkg::t_out_item o_item
);

    localparam int NW = lpu_pkg::NUM_W;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v[47:31] == '0 || v[47:31] == '1) begin
            r = v[31:0];
        end else if (v[47]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // captured item
    logic [1:0]         r_op;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [62:0] r_prod;
    logic               r_step_out;
    logic               r_use_fixed;
    logic [30:0]        r_max;
    // divider
    logic [NW-1:0]      r_quo;
    logic [31:0]        r_rem;
    logic [30:0]        r_den;
    lpu_pkg::t_out_item r_out;

    // capture-side logic
    logic signed [31:0] mult_a;
    logic signed [63:0] prod_full;
    logic [31:0]        abs_vel;
    logic [30:0]        speed;
    logic [30:0]        max_new;
    logic               is_measure;
    logic               use_fixed;
    logic [NW-1:0]      num;

    always_comb begin
        mult_a     = (i_item.op == lpu_pkg::OP_KICK) ? i_item.acceleration : i_item.velocity;
        prod_full  = 64'(mult_a) * 64'($signed({1'b0, i_item.step_size}));
        abs_vel    = i_item.velocity[31] ? 32'(-i_item.velocity) : i_item.velocity;
        speed      = abs_vel[31] ? '1 : abs_vel[30:0];
        max_new    = (speed > r_max) ? speed : r_max;
        is_measure = (i_item.op == lpu_pkg::OP_MEASURE);
        use_fixed  = !i_cfg.adaptive_enable || (max_new == '0);
        num        = NW'(i_cfg.step_fraction) * NW'(i_cfg.cell_width);
        o_status.need_div = is_measure && i_item.last_item && !use_fixed;
    end

    // restoring divide, one quotient bit per step
    logic [31:0] rem_sh;
    logic [32:0] rem_diff;

    assign rem_sh   = {r_rem[30:0], r_quo[NW-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (i_cmd.capture && is_measure) begin
            r_max <= i_item.last_item ? '0 : max_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_item.op;
            r_pos       <= i_item.position;
            r_vel       <= i_item.velocity;
            r_prod      <= prod_full[62:0];
            r_step_out  <= is_measure && i_item.last_item;
            r_use_fixed <= use_fixed;
            r_quo       <= num;
            r_rem       <= '0;
            r_den       <= max_new;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[NW-2:0], !rem_diff[32]};
            r_rem <= rem_diff[32] ? rem_sh : rem_diff[31:0];
        end
    end

    // result
    logic signed [47:0] kick_sum;
    logic signed [47:0] drift_sum;
    logic signed [31:0] drift_sat;
    logic signed [31:0] drift_wrap;
    logic [30:0]        step_sel;
    lpu_pkg::t_out_item res;

    always_comb begin
        kick_sum  = 48'(r_vel) + 48'(signed'(r_prod[62:17]));
        drift_sum = 48'(r_pos) + 48'(signed'(r_prod[62:16]));
        drift_sat = sat32(drift_sum);
        if (drift_sat[31]) begin
            drift_wrap = drift_sat + $signed({1'b0, i_cfg.period_len});
        end else if (drift_sat[30:0] >= i_cfg.period_len) begin
            drift_wrap = drift_sat - $signed({1'b0, i_cfg.period_len});
        end else begin
            drift_wrap = drift_sat;
        end

        if (r_use_fixed || (r_quo > NW'(i_cfg.fixed_step))) begin
            step_sel = i_cfg.fixed_step;
        end else begin
            step_sel = r_quo[30:0];
        end

        res.new_position = r_pos;
        res.new_velocity = r_vel;
        res.next_step    = r_step_out ? step_sel : '0;
        res.step_valid   = r_step_out;
        unique case (r_op)
            lpu_pkg::OP_KICK:  res.new_velocity = sat32(kick_sum);
            lpu_pkg::OP_DRIFT: res.new_position = drift_wrap;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    assign o_item = r_out;

endmodule

// ===== src/leapfrog_particle_update.sv =====
`timescale 1ns / 1ps
// Leapfrog kick/drift particle update, Q15.16 fixed point, one particle per transfer.
// i_in   : particle transfers (op, position, velocity, acceleration, step_size,
//          last_item). op kick updates velocity, drift updates position with a
//          periodic wrap, measure tracks the maximum speed.
// o_out  : one result per input transfer, in order. On a measure item marked last
//          it carries the next time step with step_valid set.
// i_cfg  : register writes (index, value), always ready; write only while idle.
// Timing : an item is taken, its product registered, then the result is loaded
//          into the output register; one item is in flight at a time.
//          A last measure item with adaptive stepping and a nonzero maximum first
//          runs the bit-serial quotient for the next step before its result load.
// Stall  : a finished result waits in the output register; the next item is
//          taken and worked on, and holds in its final state until the output
//          register frees.
// Reset  : synchronous, active low. Registers return to their defaults, the
//          running maximum clears and no result is pending.
module leapfrog_particle_update (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lpu_in_if.sink          i_in,
    lpu_out_if.source       o_out,
    lpu_cfg_if.sink         i_cfg
);

    lpu_pkg::t_cfg    cfg;
    lpu_pkg::t_cmd    cmd;
    lpu_pkg::t_status status;

    lpu_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr       (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    lpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lpu_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in.data),
        .i_cfg    (cfg),
        .i_cmd    (cmd),
        .o_status (status),
        .o_item   (o_out.data)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam longint S32_HI = 2147483647;
    localparam longint S32_LO = -S32_HI - 1;
    localparam logic [31:0] W_MAX = 32'h7fffffff;
    localparam logic [31:0] W_MIN = 32'h80000000;
    localparam logic [30:0] U_MAX = 31'h7fffffff;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lpu_in_if  in_if ();
    lpu_out_if out_if ();
    lpu_cfg_if cfg_if ();

    leapfrog_particle_update dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    lpu_pkg::t_out_item expected_updates[$];
    lpu_pkg::t_cfg      pred_cfg;
    logic [30:0] pred_max_speed;
    logic [30:0] last_step_pred;
    int          mismatches = 0;
    int          particles_sent = 0;
    int          tx_idle_pct = 18;
    int          rx_idle_pct = 18;
    int          rx_hold = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
    end

    function automatic logic [31:0] sat32(longint v);
        if (v > S32_HI) return W_MAX;
        if (v < S32_LO) return W_MIN;
        return v[31:0];
    endfunction

    // Kick/drift/measure prediction; updates the running maximum in order of transfer.
    function automatic lpu_pkg::t_out_item predict_update(lpu_pkg::t_in_item it);
        lpu_pkg::t_out_item r;
        longint            pos, vel, acc, stp, box, mag;
        longint unsigned   num, dt;
        logic [30:0]       speed;
        pos = longint'($signed(it.position));
        vel = longint'($signed(it.velocity));
        acc = longint'($signed(it.acceleration));
        stp = longint'({33'b0, it.step_size});
        r.new_position = it.position;
        r.new_velocity = it.velocity;
        r.next_step    = '0;
        r.step_valid   = 1'b0;
        case (it.op)
            lpu_pkg::OP_KICK: begin
                r.new_velocity = sat32(vel + ((acc * stp) >>> 17));
            end
            lpu_pkg::OP_DRIFT: begin
                box = longint'({33'b0, pred_cfg.period_len});
                pos = longint'($signed(sat32(pos + ((vel * stp) >>> 16))));
                if (pos < 0) pos = pos + box;
                else if (pos >= box) pos = pos - box;
                r.new_position = sat32(pos);
            end
            lpu_pkg::OP_MEASURE: begin
                mag = (vel < 0) ? -vel : vel;
                speed = (mag > S32_HI) ? U_MAX : mag[30:0];
                if (speed > pred_max_speed) pred_max_speed = speed;
                if (it.last_item) begin
                    if (!pred_cfg.adaptive_enable || pred_max_speed == 0) begin
                        r.next_step = pred_cfg.fixed_step;
                    end else begin
                        num = {47'b0, pred_cfg.step_fraction} * {33'b0, pred_cfg.cell_width};
                        dt = num / {33'b0, pred_max_speed};
                        r.next_step = (dt > {33'b0, pred_cfg.fixed_step}) ?
                                      pred_cfg.fixed_step : dt[30:0];
                    end
                    r.step_valid = 1'b1;
                    pred_max_speed = '0;
                    last_step_pred = r.next_step;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic lpu_pkg::t_in_item particle(logic [1:0] op, logic [31:0] pos,
                                                   logic [31:0] vel, logic [31:0] acc,
                                                   logic [30:0] stp, logic last);
        lpu_pkg::t_in_item it;
        it.op           = op;
        it.position     = pos;
        it.velocity     = vel;
        it.acceleration = acc;
        it.step_size    = stp;
        it.last_item    = last;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return W_MAX;
            1: return W_MIN;
            2: return 32'($urandom_range(2000)) - 32'd1000;
            3: return 32'hffffffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_scaled();
        logic [31:0] r;
        int          sh;
        sh = $urandom_range(31, 1);
        r = $urandom() & ((32'h1 << sh) - 32'h1);
        if ($urandom_range(1)) r = -r;
        return r;
    endfunction

    function automatic logic [30:0] rand_step();
        case ($urandom_range(7))
            0: return U_MAX;
            1: return '0;
            2, 3, 4: return 31'($urandom_range(32'h10000, 1));
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_particle(input lpu_pkg::t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.data  = it;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        expected_updates.push_back(predict_update(it));
        particles_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_if.data.index = idx;
        cfg_if.data.value = val;
        cfg_if.valid      = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            lpu_pkg::REG_PERIOD_LEN:      pred_cfg.period_len      = val[30:0];
            lpu_pkg::REG_CELL_WIDTH:      pred_cfg.cell_width      = val[30:0];
            lpu_pkg::REG_STEP_FRACTION:   pred_cfg.step_fraction   = val[16:0];
            lpu_pkg::REG_FIXED_STEP:      pred_cfg.fixed_step      = val[30:0];
            lpu_pkg::REG_ADAPTIVE_ENABLE: pred_cfg.adaptive_enable = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic write_all_registers(input logic [30:0] box, input logic [30:0] cw,
                                       input logic [16:0] frac, input logic [30:0] fixed,
                                       input logic adaptive);
        wait_idle();
        write_register(lpu_pkg::REG_PERIOD_LEN, {1'b0, box});
        write_register(lpu_pkg::REG_CELL_WIDTH, {1'b0, cw});
        write_register(lpu_pkg::REG_STEP_FRACTION, {15'b0, frac});
        write_register(lpu_pkg::REG_FIXED_STEP, {1'b0, fixed});
        write_register(lpu_pkg::REG_ADAPTIVE_ENABLE, {31'b0, adaptive});
    endtask

    // Measure a batch, then kick and drift the batch with the step just chosen.
    task automatic run_leapfrog_pass(input int n);
        logic [31:0] pos;
        for (int i = 0; i < n; i++)
            send_particle(particle(lpu_pkg::OP_MEASURE, rand_word(), rand_scaled(),
                                   rand_word(), rand_step(), i == n - 1));
        for (int i = 0; i < n; i++)
            send_particle(particle(lpu_pkg::OP_KICK, rand_word(), rand_scaled(),
                                   rand_scaled(), last_step_pred, 1'b0));
        for (int i = 0; i < n; i++) begin
            pos = 32'($urandom_range(32'(pred_cfg.period_len) - 32'd1, 0));
            send_particle(particle(lpu_pkg::OP_DRIFT, pos, rand_scaled(), rand_word(),
                                   last_step_pred, 1'b0));
        end
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_particle(particle(2'($urandom_range(3)), rand_word(), rand_word(),
                                   rand_word(), rand_step(), 1'($urandom_range(1))));
    endtask

    task automatic test_edge_cases();
        send_particle(particle(lpu_pkg::OP_KICK, 32'd0, W_MAX, W_MAX, U_MAX, 1'b0));
        send_particle(particle(lpu_pkg::OP_KICK, 32'd0, W_MIN, W_MIN, U_MAX, 1'b0));
        send_particle(particle(lpu_pkg::OP_KICK, 32'd7, 32'd0, 32'hffffffff, 31'd1, 1'b0));
        send_particle(particle(lpu_pkg::OP_KICK, 32'd7, 32'd99, W_MAX, 31'd0, 1'b1));
        send_particle(particle(lpu_pkg::OP_DRIFT, W_MAX, W_MAX, 32'd0, U_MAX, 1'b0));
        send_particle(particle(lpu_pkg::OP_DRIFT, W_MIN, W_MIN, 32'd0, U_MAX, 1'b0));
        send_particle(particle(lpu_pkg::OP_DRIFT, 32'd4194303, 32'h10000, 32'd0,
                               31'h10000, 1'b0));
        send_particle(particle(lpu_pkg::OP_DRIFT, 32'd0, 32'hffffffff, 32'd0, 31'd1, 1'b1));
        send_particle(particle(lpu_pkg::OP_DRIFT, W_MAX, 32'd0, 32'd0, 31'd0, 1'b0));
        send_particle(particle(2'd3, W_MIN, W_MAX, W_MAX, U_MAX, 1'b1));
        send_particle(particle(lpu_pkg::OP_MEASURE, 32'd1, W_MIN, 32'd0, 31'd0, 1'b0));
        send_particle(particle(lpu_pkg::OP_MEASURE, 32'd1, 32'd5, 32'd0, 31'd0, 1'b1));
        write_all_registers(31'd4194304, 31'h10000, 17'h8000, 31'd655, 1'b1);
        send_particle(particle(lpu_pkg::OP_MEASURE, 32'd0, 32'd0, 32'd0, 31'd0, 1'b1));
        send_particle(particle(lpu_pkg::OP_MEASURE, 32'd0, 32'hffff0000, 32'd0, 31'd0, 1'b1));
        write_all_registers(31'd4194304, 31'h10000, 17'h8000, U_MAX, 1'b1);
        send_particle(particle(lpu_pkg::OP_MEASURE, 32'd0, W_MIN, 32'd0, 31'd0, 1'b1));
        send_particle(particle(lpu_pkg::OP_MEASURE, 32'd0, 32'd3, 32'd0, 31'd0, 1'b1));
        write_all_registers(31'd0, U_MAX, 17'd0, U_MAX, 1'b1);
        send_particle(particle(lpu_pkg::OP_DRIFT, 32'hfffffffb, 32'd0, 32'd0, 31'd0, 1'b0));
        send_particle(particle(lpu_pkg::OP_DRIFT, 32'd100, 32'h10000, 32'd0, 31'h10000, 1'b0));
        send_particle(particle(lpu_pkg::OP_MEASURE, 32'd0, 32'd1, 32'd0, 31'd0, 1'b1));
        write_all_registers(31'd1, U_MAX, 17'h10000, U_MAX, 1'b1);
        send_particle(particle(lpu_pkg::OP_MEASURE, 32'd0, 32'd1, 32'd0, 31'd0, 1'b1));
        send_particle(particle(lpu_pkg::OP_DRIFT, 32'd0, 32'd0, 32'd0, 31'd0, 1'b0));
    endtask

    task automatic test_register_extremes();
        write_all_registers(31'd1, 31'd1, 17'd0, 31'd1, 1'b1);
        run_leapfrog_pass(6);
        write_all_registers(U_MAX, U_MAX, 17'h10000, U_MAX, 1'b1);
        run_leapfrog_pass(6);
        write_all_registers(U_MAX, 31'd1, 17'h10000, 31'd1, 1'b0);
        run_leapfrog_pass(6);
        write_all_registers(lpu_pkg::RST_PERIOD_LEN, lpu_pkg::RST_CELL_WIDTH,
                            lpu_pkg::RST_STEP_FRACTION, lpu_pkg::RST_FIXED_STEP, 1'b0);
        run_leapfrog_pass(4);
    endtask

    task automatic test_output_stall();
        wait_idle();
        tx_idle_pct = 0;
        rx_hold = 300;
        send_noise(40);
        run_leapfrog_pass(5);
        tx_idle_pct = 18;
        wait_idle();
        send_noise(10);
    endtask

    task automatic test_random_traffic();
        logic [30:0] box, cw, fixed;
        int          goal;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(3))
                0: box = 31'd1;
                1: box = U_MAX;
                default: box = 31'($urandom_range(32'h10000000, 32'h10000));
            endcase
            cw = ($urandom_range(1)) ? 31'($urandom_range(32'h100000, 1)) : 31'($urandom());
            if (cw == 0) cw = 31'd1;
            case ($urandom_range(3))
                0: fixed = 31'd1;
                1: fixed = U_MAX;
                default: fixed = 31'($urandom_range(32'h100000, 1));
            endcase
            write_all_registers(box, cw, 17'($urandom_range(32'h10000, 0)), fixed,
                                1'($urandom_range(3) != 0));
            tx_idle_pct = (phase == 3) ? 0 : 18;
            rx_idle_pct = (phase == 3) ? 0 : 18;
            goal = particles_sent + 220;
            while (particles_sent < goal) begin
                if ($urandom_range(9) < 7) run_leapfrog_pass($urandom_range(12, 1));
                else send_noise($urandom_range(6, 1));
                if ($urandom_range(19) == 0) wait_idle();
            end
        end
        tx_idle_pct = 18;
        rx_idle_pct = 18;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready = 1'b0;
        end else if (rx_hold > 0) begin
            out_if.ready = 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            out_if.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        lpu_pkg::t_out_item got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (expected_updates.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %h", got));
            end else begin
                want = expected_updates.pop_front();
                if (got.new_position !== want.new_position)
                    report_mismatch($sformatf("new_position %h, expected %h",
                                              got.new_position, want.new_position));
                if (got.new_velocity !== want.new_velocity)
                    report_mismatch($sformatf("new_velocity %h, expected %h",
                                              got.new_velocity, want.new_velocity));
                if (got.next_step !== want.next_step)
                    report_mismatch($sformatf("next_step %h, expected %h",
                                              got.next_step, want.next_step));
                if (got.step_valid !== want.step_valid)
                    report_mismatch($sformatf("step_valid %b, expected %b",
                                              got.step_valid, want.step_valid));
            end
        end
    end

    initial begin
        pred_cfg.period_len      = lpu_pkg::RST_PERIOD_LEN;
        pred_cfg.cell_width      = lpu_pkg::RST_CELL_WIDTH;
        pred_cfg.step_fraction   = lpu_pkg::RST_STEP_FRACTION;
        pred_cfg.fixed_step      = lpu_pkg::RST_FIXED_STEP;
        pred_cfg.adaptive_enable = 1'b0;
        pred_max_speed = '0;
        last_step_pred = lpu_pkg::RST_FIXED_STEP;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_edge_cases();
        test_register_extremes();
        test_output_stall();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("TIMEOUT at %0t", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
